### rtl/ute_pkg.sv
// Shared types and constants for the UDP table evaluator.
package ute_pkg;

  localparam int MASK_W = 11;

  typedef enum logic [1:0] {
    OP_LEVEL   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_PORT    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [1:0] VAL_0 = 2'd0;
  localparam logic [1:0] VAL_1 = 2'd1;
  localparam logic [1:0] VAL_X = 2'd2;

  localparam logic [1:0] KIND_0    = 2'd0;
  localparam logic [1:0] KIND_1    = 2'd1;
  localparam logic [1:0] KIND_X    = 2'd2;
  localparam logic [1:0] KIND_HOLD = 2'd3;

  localparam logic [1:0] REG_PORTS_USED = 2'd0;
  localparam logic [1:0] REG_SEQ_MODE   = 2'd1;
  localparam logic [1:0] REG_INIT_OUT   = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [MASK_W-1:0] m0;
    logic [MASK_W-1:0] m1;
    logic [MASK_W-1:0] mx;
  } lrow_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [MASK_W-1:0] m0;
    logic [MASK_W-1:0] m1;
    logic [MASK_W-1:0] mx;
    logic [3:0]        pos;
    logic [2:0]        from;
  } erow_t;

  function automatic logic [1:0] norm_val(input logic [1:0] v);
    norm_val = (v == VAL_0 || v == VAL_1) ? v : VAL_X;
  endfunction

endpackage

### rtl/udp_table_evaluator_unit.sv
// Top level of the UDP table evaluator: row stores, scan sequencer and shared row matcher.
//
// Evaluates a user-defined primitive held as level rows and edge rows. Issue a
// transaction by raising start while busy is low. Row writes and restarts
// answer on the next cycle with done high for one cycle. A port change that
// lands in range starts a scan: every level row is read one per cycle, then
// every edge row, through one shared matcher fed from the registered read of
// the row memories; the answer follows after the drain and finish states,
// and busy stays high until then. done, out_value and out_changed are valid
// for that single cycle only; the receiver cannot stall, so capture them
// when done is high.
// Configuration writes through cfg_write/cfg_index/cfg_data take effect at
// once and must only be issued while the block is idle.
module udp_table_evaluator_unit #(
  parameter int MAX_INPUTS = 10,
  parameter int LEVEL_ROWS = 32,
  parameter int EDGE_ROWS  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [3:0]                cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [4:0]                row_index,
  input  logic                      row_valid,
  input  logic [1:0]                row_kind,
  input  logic [ute_pkg::MASK_W-1:0] row_mask_zero,
  input  logic [ute_pkg::MASK_W-1:0] row_mask_one,
  input  logic [ute_pkg::MASK_W-1:0] row_mask_unknown,
  input  logic [3:0]                edge_column,
  input  logic [2:0]                edge_from_set,
  input  logic [3:0]                port_index,
  input  logic [1:0]                port_value,
  output logic                      done,
  output logic [1:0]                out_value,
  output logic                      out_changed
);
  import ute_pkg::*;

  localparam int LA = (LEVEL_ROWS > 1) ? $clog2(LEVEL_ROWS) : 1;
  localparam int EA = (EDGE_ROWS > 1) ? $clog2(EDGE_ROWS) : 1;
  localparam int CW = (LA > EA) ? LA : EA;
  localparam int PW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LSCAN  = 5'b00010,
    S_ESCAN  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [3:0] ports_used;
  logic       sequential_mode;
  logic [1:0] initial_output;

  // Primitive state
  logic [1:0] levels [MAX_INPUTS];
  logic [1:0] cur;

  // Row stores: valid bits in flops, row bodies in memories
  logic [LEVEL_ROWS-1:0] lvalid;
  logic [EDGE_ROWS-1:0]  evalid;
  lrow_t level_mem [LEVEL_ROWS];
  erow_t edge_mem  [EDGE_ROWS];

  // Scan context
  logic [CW-1:0] cnt;
  logic [3:0]    port_q;
  logic [1:0]    prev_q;
  logic          same_q;
  logic [3:0]    lfound;
  logic [3:0]    efound;

  // Read stage
  lrow_t l_q;
  erow_t e_q;
  logic  rd_live;
  logic  rd_edge;
  logic  rd_ok;

  int         n_eff;
  logic       accept;
  logic       slot_l_ok;
  logic       slot_e_ok;
  logic       port_ok;
  logic [1:0] new_val;
  logic [PW-1:0] pidx;

  // Matcher signals
  logic [1:0]        m_kind;
  logic [MASK_W-1:0] m_m0, m_m1, m_mx;
  logic              m_hit;
  logic              e_extra;
  logic [2:0]        from_bit;
  logic [1:0]        scan_result;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign out_value = cur;

  always_comb begin
    if (ports_used == 4'd0) begin
      n_eff = 1;
    end else if (int'(ports_used) > MAX_INPUTS) begin
      n_eff = MAX_INPUTS;
    end else begin
      n_eff = int'(ports_used);
    end
  end

  assign slot_l_ok = int'(row_index) < LEVEL_ROWS;
  assign slot_e_ok = int'(row_index) < EDGE_ROWS;
  assign port_ok   = int'(port_index) < n_eff;
  assign new_val   = norm_val(port_value);
  assign pidx      = PW'(port_index);

  // Shared row matcher: one row per cycle from the registered read
  always_comb begin
    logic [MASK_W-1:0] sel;
    logic [MASK_W-1:0] sh;
    sel    = '0;
    sh     = '0;
    m_kind = rd_edge ? e_q.kind : l_q.kind;
    m_m0   = rd_edge ? e_q.m0 : l_q.m0;
    m_m1   = rd_edge ? e_q.m1 : l_q.m1;
    m_mx   = rd_edge ? e_q.mx : l_q.mx;
    m_hit  = 1'b1;
    for (int c = 0; c < MAX_INPUTS; c++) begin
      if (c < n_eff) begin
        sel = (levels[c] == VAL_0) ? m_m0 : (levels[c] == VAL_1) ? m_m1 : m_mx;
        sh  = sel >> c;
        if (c >= MASK_W || !sh[0]) begin
          m_hit = 1'b0;
        end
      end
    end
    // Output column sits right after the inputs in use
    if (sequential_mode) begin
      sel = (cur == VAL_0) ? m_m0 : (cur == VAL_1) ? m_m1 : m_mx;
      sh  = sel >> n_eff;
      if (n_eff >= MASK_W || !sh[0]) begin
        m_hit = 1'b0;
      end
    end
  end

  assign from_bit = (prev_q == VAL_0) ? 3'b001 : (prev_q == VAL_1) ? 3'b100 : 3'b010;
  assign e_extra  = (e_q.pos == port_q) && ((e_q.from & from_bit) != 3'b000);

  // Priority resolution once both passes are done
  always_comb begin
    if (!sequential_mode) begin
      priority if (lfound[KIND_0]) scan_result = VAL_0;
      else if (lfound[KIND_1])     scan_result = VAL_1;
      else                         scan_result = VAL_X;
    end else begin
      priority if (same_q)          scan_result = cur;
      else if (lfound[KIND_0])      scan_result = VAL_0;
      else if (lfound[KIND_1])      scan_result = VAL_1;
      else if (lfound[KIND_X])      scan_result = VAL_X;
      else if (lfound[KIND_HOLD])   scan_result = cur;
      else if (efound[KIND_0])      scan_result = VAL_0;
      else if (efound[KIND_1])      scan_result = VAL_1;
      else if (efound[KIND_HOLD])   scan_result = cur;
      else                          scan_result = VAL_X;
    end
  end

  // Row memories: write on a row transaction, read at the scan address
  always_ff @(posedge clk) begin
    if (accept && op_t'(opcode) == OP_LEVEL && slot_l_ok) begin
      level_mem[LA'(row_index)] <= '{kind: row_kind, m0: row_mask_zero,
                                     m1: row_mask_one, mx: row_mask_unknown};
    end
    if (accept && op_t'(opcode) == OP_EDGE && slot_e_ok) begin
      edge_mem[EA'(row_index)] <= '{kind: row_kind, m0: row_mask_zero,
                                    m1: row_mask_one, mx: row_mask_unknown,
                                    pos: edge_column, from: edge_from_set};
    end
    l_q <= level_mem[cnt[LA-1:0]];
    e_q <= edge_mem[cnt[EA-1:0]];
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      ports_used      <= 4'd3;
      sequential_mode <= 1'b1;
      initial_output  <= VAL_X;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PORTS_USED: ports_used      <= cfg_data;
        REG_SEQ_MODE:   sequential_mode <= cfg_data[0];
        REG_INIT_OUT:   initial_output  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and primitive state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= VAL_X;
      lvalid      <= '0;
      evalid      <= '0;
      done        <= 1'b0;
      out_changed <= 1'b0;
      rd_live     <= 1'b0;
      rd_edge     <= 1'b0;
      rd_ok       <= 1'b0;
      cnt         <= '0;
      lfound      <= '0;
      efound      <= '0;
      for (int i = 0; i < MAX_INPUTS; i++) levels[i] <= VAL_X;
    end else begin
      done    <= 1'b0;
      rd_live <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op_t'(opcode))
              OP_LEVEL: begin
                if (slot_l_ok) lvalid[LA'(row_index)] <= row_valid;
                done        <= 1'b1;
                out_changed <= 1'b0;
              end
              OP_EDGE: begin
                if (slot_e_ok) evalid[EA'(row_index)] <= row_valid;
                done        <= 1'b1;
                out_changed <= 1'b0;
              end
              OP_PORT: begin
                if (port_ok) begin
                  // Latch the change and start the level pass
                  levels[pidx] <= new_val;
                  port_q       <= port_index;
                  prev_q       <= levels[pidx];
                  same_q       <= (levels[pidx] == new_val);
                  lfound       <= '0;
                  efound       <= '0;
                  cnt          <= '0;
                  state        <= S_LSCAN;
                end else begin
                  done        <= 1'b1;
                  out_changed <= 1'b0;
                end
              end
              OP_RESTART: begin
                for (int i = 0; i < MAX_INPUTS; i++) levels[i] <= VAL_X;
                cur         <= sequential_mode ? norm_val(initial_output) : VAL_X;
                out_changed <= (sequential_mode ? norm_val(initial_output) : VAL_X) != cur;
                done        <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_LSCAN: begin
          rd_live <= 1'b1;
          rd_edge <= 1'b0;
          rd_ok   <= lvalid[cnt[LA-1:0]];
          if (cnt == CW'(LEVEL_ROWS - 1)) begin
            cnt   <= '0;
            state <= S_ESCAN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ESCAN: begin
          rd_live <= 1'b1;
          rd_edge <= 1'b1;
          rd_ok   <= evalid[cnt[EA-1:0]];
          if (cnt == CW'(EDGE_ROWS - 1)) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          cur         <= scan_result;
          out_changed <= scan_result != cur;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Record which result kinds found a matching row
      if (rd_live && rd_ok && m_hit) begin
        if (rd_edge) begin
          if (e_extra) efound[m_kind] <= 1'b1;
        end else begin
          lfound[m_kind] <= 1'b1;
        end
      end
    end
  end

endmodule
